// ----- hdl/kmst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared widths and defaults for the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int DEF_MAX_VERTS = 64;
  localparam int DEF_MAX_EDGES = 256;

  localparam int VID_W  = 6;   // vertex field width
  localparam int WGT_W  = 16;  // weight field width
  localparam int COST_W = 22;  // total cost width
  localparam int VC_W   = 7;   // vertex_count register width

  // One stored edge.
  typedef struct packed {
    logic [VID_W-1:0]        src;
    logic [VID_W-1:0]        dest;
    logic signed [WGT_W-1:0] weight;
  } edge_t;

endpackage

// ----- hdl/kruskal_minimum_spanning_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree
// Loads an edge list into an edge memory, ranks it stably by weight, then
// walks it with a union-find held in a parent memory and emits tree edges.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------
//  edge in  | start, busy            | edge_src, edge_dest, edge_weight,
//           |                        | last_edge
//  result   | result_strobe          | is_summary, tree_src, tree_dest,
//           |                        | tree_weight, total_cost, spanning,
//           |                        | store_overflow, last_result
//  config   | cfg_we                 | cfg_data (vertex_count)
//
// During loading busy is low and a word is taken every cycle while start
// is high. The word marked last_edge starts the run and busy stays high
// until the summary word is produced.
// A run first resets the parent memory, then ranks the stored edges with a
// rank sort (one edge memory read per compare), then fetches and checks
// each walked edge. For an edge with both endpoints in range it follows
// each endpoint to its root through parent memory lookups and then links
// the two roots if they differ. A walk check and the summary end the run.
// Reset (synchronous, rst high) empties the edge list and sets vertex_count
// to 64. Results are strobed for one cycle each; the receiver cannot stall.
//
module kruskal_minimum_spanning_tree #(
  parameter int MAX_VERTS = kmst_pkg::DEF_MAX_VERTS,
  parameter int MAX_EDGES = kmst_pkg::DEF_MAX_EDGES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [kmst_pkg::VID_W-1:0]        edge_src,
  input  logic [kmst_pkg::VID_W-1:0]        edge_dest,
  input  logic signed [kmst_pkg::WGT_W-1:0] edge_weight,
  input  logic                              last_edge,
  input  logic                              cfg_we,
  input  logic [kmst_pkg::VC_W-1:0]         cfg_data,
  output logic                              result_strobe,
  output logic                              is_summary,
  output logic [kmst_pkg::VID_W-1:0]        tree_src,
  output logic [kmst_pkg::VID_W-1:0]        tree_dest,
  output logic signed [kmst_pkg::WGT_W-1:0] tree_weight,
  output logic signed [kmst_pkg::COST_W-1:0] total_cost,
  output logic                              spanning,
  output logic                              store_overflow,
  output logic                              last_result
);

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = EW + 1;
  localparam int VW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int VCW = kmst_pkg::VC_W;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT, S_SORT_I, S_SORT_IW, S_SORT_J, S_SORT_JC, S_SORT_WR,
    S_WALK, S_WALK_O, S_WALK_E, S_FIND_RD, S_FIND_CK, S_LINK, S_SUM
  } state_t;

  state_t state;

  // Memories: edge list, sorted order (edge indexes) and the parent table.
  kmst_pkg::edge_t edge_mem [MAX_EDGES];
  logic [EW-1:0]   order_mem [MAX_EDGES];
  logic [VW-1:0]   parent_mem [MAX_VERTS];

  kmst_pkg::edge_t edge_q;
  logic [EW-1:0]   order_q;
  logic [VW-1:0]   parent_q;

  logic [EW-1:0]   edge_raddr;
  logic            edge_we;
  logic            order_we;
  logic            parent_we;
  logic [VW-1:0]   parent_waddr;
  logic [VW-1:0]   parent_wdata;

  logic [VCW-1:0]  vertex_count;
  logic [VCW-1:0]  nv;          // clamped vertex count latched for the run
  logic [VCW-1:0]  vc_clamped;
  logic [CW-1:0]   fill;
  logic            overflow_seen;
  logic [CW-1:0]   idx_i;
  logic [CW-1:0]   idx_j;
  logic [EW-1:0]   rank;
  logic signed [kmst_pkg::WGT_W-1:0] wi;
  logic [VW-1:0]   kinit;
  logic [VCW-1:0]  acc_count;
  logic [kmst_pkg::COST_W-1:0] cost_sum;
  kmst_pkg::edge_t cur;
  logic [VW-1:0]   r;
  logic [VW-1:0]   ru;
  logic [VW-1:0]   rv;
  logic            find_dest;

  assign busy = (state != S_LOAD);

  always_comb begin
    if (vertex_count == '0) begin
      vc_clamped = VCW'(1);
    end else if (vertex_count > VCW'(MAX_VERTS)) begin
      vc_clamped = VCW'(MAX_VERTS);
    end else begin
      vc_clamped = vertex_count;
    end
  end

  // The edge memory is read by the sort (outer and inner index) and by the
  // walk (through the order memory).
  always_comb begin
    unique case (state)
      S_SORT_I: edge_raddr = idx_i[EW-1:0];
      S_SORT_J: edge_raddr = idx_j[EW-1:0];
      default:  edge_raddr = order_q;
    endcase
  end

  assign edge_we   = (state == S_LOAD) && start && (fill < CW'(MAX_EDGES));
  assign order_we  = (state == S_SORT_WR);
  assign parent_we = (state == S_INIT) || ((state == S_LINK) && (ru != rv));
  assign parent_waddr = (state == S_INIT) ? kinit : rv;
  assign parent_wdata = (state == S_INIT) ? kinit : ru;

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[fill[EW-1:0]] <= '{src: edge_src, dest: edge_dest, weight: edge_weight};
    end
    edge_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[rank] <= idx_i[EW-1:0];
    end
    order_q <= order_mem[idx_i[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (parent_we) begin
      parent_mem[parent_waddr] <= parent_wdata;
    end
    parent_q <= parent_mem[r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      vertex_count  <= VCW'(64);
      fill          <= '0;
      overflow_seen <= 1'b0;
      acc_count     <= '0;
      cost_sum      <= '0;
      result_strobe <= 1'b0;
      nv            <= VCW'(1);
      idx_i         <= '0;
      idx_j         <= '0;
      rank          <= '0;
      kinit         <= '0;
      r             <= '0;
      find_dest     <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_we) begin
        vertex_count <= cfg_data;
      end
      unique case (state)
        S_LOAD: begin
          if (start) begin
            if (fill < CW'(MAX_EDGES)) begin
              fill <= fill + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (last_edge) begin
              nv    <= vc_clamped;
              kinit <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          kinit <= kinit + VW'(1);
          if (kinit == VW'(MAX_VERTS - 1)) begin
            idx_i <= '0;
            state <= S_SORT_I;
          end
        end
        // Rank sort: the final place of edge i is the number of edges with a
        // lower weight, plus those of equal weight stored before it.
        S_SORT_I: begin
          if (idx_i == fill) begin
            idx_i     <= '0;
            acc_count <= '0;
            cost_sum  <= '0;
            state     <= S_WALK;
          end else begin
            state <= S_SORT_IW;
          end
        end
        S_SORT_IW: begin
          wi    <= edge_q.weight;
          idx_j <= '0;
          rank  <= '0;
          state <= S_SORT_J;
        end
        S_SORT_J: begin
          state <= (idx_j == fill) ? S_SORT_WR : S_SORT_JC;
        end
        S_SORT_JC: begin
          if ((edge_q.weight < wi) || ((edge_q.weight == wi) && (idx_j < idx_i))) begin
            rank <= rank + EW'(1);
          end
          idx_j <= idx_j + CW'(1);
          state <= S_SORT_J;
        end
        S_SORT_WR: begin
          idx_i <= idx_i + CW'(1);
          state <= S_SORT_I;
        end
        // Walk of the sorted list; idx_i now addresses the order memory.
        S_WALK: begin
          if ((idx_i == fill) || (acc_count == nv - VCW'(1))) begin
            state <= S_SUM;
          end else begin
            state <= S_WALK_O;
          end
        end
        S_WALK_O: begin
          state <= S_WALK_E;
        end
        S_WALK_E: begin
          cur <= edge_q;
          if (({1'b0, edge_q.src} >= nv) || ({1'b0, edge_q.dest} >= nv)) begin
            idx_i <= idx_i + CW'(1);
            state <= S_WALK;
          end else begin
            r         <= edge_q.src[VW-1:0];
            find_dest <= 1'b0;
            state     <= S_FIND_RD;
          end
        end
        S_FIND_RD: begin
          state <= S_FIND_CK;
        end
        S_FIND_CK: begin
          if (parent_q == r) begin
            if (!find_dest) begin
              ru        <= r;
              r         <= cur.dest[VW-1:0];
              find_dest <= 1'b1;
              state     <= S_FIND_RD;
            end else begin
              rv    <= r;
              state <= S_LINK;
            end
          end else begin
            r     <= parent_q;
            state <= S_FIND_RD;
          end
        end
        S_LINK: begin
          if (ru != rv) begin
            result_strobe  <= 1'b1;
            is_summary     <= 1'b0;
            tree_src       <= cur.src;
            tree_dest      <= cur.dest;
            tree_weight    <= cur.weight;
            total_cost     <= '0;
            spanning       <= 1'b0;
            store_overflow <= 1'b0;
            last_result    <= 1'b0;
            cost_sum  <= cost_sum + kmst_pkg::COST_W'(cur.weight);
            acc_count <= acc_count + VCW'(1);
          end
          idx_i <= idx_i + CW'(1);
          state <= S_WALK;
        end
        S_SUM: begin
          result_strobe  <= 1'b1;
          is_summary     <= 1'b1;
          tree_src       <= '0;
          tree_dest      <= '0;
          tree_weight    <= '0;
          total_cost     <= cost_sum;
          spanning       <= (acc_count == nv - VCW'(1));
          store_overflow <= overflow_seen;
          last_result    <= 1'b1;
          fill           <= '0;
          overflow_seen  <= 1'b0;
          acc_count      <= '0;
          cost_sum       <= '0;
          state          <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // The summary word closes the run, so the block is ready again with it.
  a_summary_idle: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && is_summary) |-> !busy)
    else $error("summary word while still busy");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    acc_count <= nv)
    else $error("accepted edge count beyond vertex count");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_EDGES))
    else $error("edge fill beyond capacity");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && last_edge))
    else $error("run started without a last edge");

endmodule

// ----- tb/tb_kruskal_minimum_spanning_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kruskal_minimum_spanning_tree
// Self-checking bench for the Kruskal spanning tree block. Edge words are
// loaded in random bursts. Each graph closed by last_edge is worked out by a
// local union-find model. Every strobed result word is compared with it.
// ----------------------------------------------------------------------------
module tb_kruskal_minimum_spanning_tree;

  localparam int NVERT     = 64;
  localparam int NEDGE     = 256;
  localparam int WDOG_MAX  = 2000000;  // idle limit; must outlast the sort of a run with a full edge store
  localparam int NO_CFG    = -1;

  // One result word as the block presents it.
  typedef struct packed {
    logic                               summ;
    logic [kmst_pkg::VID_W-1:0]         src;
    logic [kmst_pkg::VID_W-1:0]         dest;
    logic signed [kmst_pkg::WGT_W-1:0]  weight;
    logic signed [kmst_pkg::COST_W-1:0] cost;
    logic                               span;
    logic                               ovf;
    logic                               last;
  } tree_word_t;

  // One row of the directed table. A row with typed results replaces the
  // model's summary word with the one written here.
  typedef struct {
    int              cfg;
    logic [5:0]      src;
    logic [5:0]      dest;
    logic [15:0]     weight;
    logic            last;
    bit              typed;
    tree_word_t      word;
  } edge_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [kmst_pkg::VID_W-1:0] edge_src;
  logic [kmst_pkg::VID_W-1:0] edge_dest;
  logic signed [kmst_pkg::WGT_W-1:0] edge_weight;
  logic last_edge;
  logic cfg_we;
  logic [kmst_pkg::VC_W-1:0] cfg_data;
  logic result_strobe;
  logic is_summary;
  logic [kmst_pkg::VID_W-1:0] tree_src;
  logic [kmst_pkg::VID_W-1:0] tree_dest;
  logic signed [kmst_pkg::WGT_W-1:0] tree_weight;
  logic signed [kmst_pkg::COST_W-1:0] total_cost;
  logic spanning;
  logic store_overflow;
  logic last_result;

  kruskal_minimum_spanning_tree i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .edge_src(edge_src), .edge_dest(edge_dest), .edge_weight(edge_weight),
    .last_edge(last_edge), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .is_summary(is_summary),
    .tree_src(tree_src), .tree_dest(tree_dest), .tree_weight(tree_weight),
    .total_cost(total_cost), .spanning(spanning),
    .store_overflow(store_overflow), .last_result(last_result)
  );

  // Local copy of the block's state: the loaded edge list and the register.
  kmst_pkg::edge_t           graph_edges[NEDGE];
  int                        graph_fill;
  bit                        graph_dropped;
  logic [kmst_pkg::VC_W-1:0] vert_reg;
  tree_word_t                tree_words_due[$];

  int errors;
  int idle_cycles;
  int items_sent;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Root of a vertex in the union-find parent table. Like the block, this
  // follows parent links to the root without path compression.
  function automatic int find_root(input int parent[NVERT], input int v);
    int r;
    r = v;
    while (parent[r] != r) r = parent[r];
    return r;
  endfunction

  // Takes one edge word into the graph and, on the closing word, works out
  // the spanning tree words and the summary.
  task automatic add_edge_and_solve(input logic [5:0] s, input logic [5:0] d,
                                    input logic [15:0] w, input logic lst);
    kmst_pkg::edge_t ranked[NEDGE];
    kmst_pkg::edge_t cur;
    int parent[NVERT];
    int nv, need, taken, j, ru, rv;
    logic signed [kmst_pkg::COST_W-1:0] sum;
    tree_word_t tw;
    if (graph_fill < NEDGE) begin
      graph_edges[graph_fill] = '{src: s, dest: d, weight: w};
      graph_fill++;
    end else begin
      graph_dropped = 1'b1;
    end
    if (!lst) return;
    nv = (vert_reg < 1) ? 1 : (vert_reg > NVERT) ? NVERT : int'(vert_reg);
    need = nv - 1;
    // Stable insertion sort on signed weight: equal weights keep load order.
    for (int i = 0; i < graph_fill; i++) begin
      cur = graph_edges[i];
      j = i;
      while (j > 0 && ranked[j-1].weight > cur.weight) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = cur;
    end
    for (int i = 0; i < NVERT; i++) parent[i] = i;
    taken = 0;
    sum = '0;
    for (int i = 0; i < graph_fill && taken < need; i++) begin
      if (ranked[i].src < nv && ranked[i].dest < nv) begin
        ru = find_root(parent, ranked[i].src);
        rv = find_root(parent, ranked[i].dest);
        if (ru != rv) begin
          parent[rv] = ru;
          sum = sum + kmst_pkg::COST_W'(ranked[i].weight);
          tw = '0;
          tw.src = ranked[i].src;
          tw.dest = ranked[i].dest;
          tw.weight = ranked[i].weight;
          tree_words_due.push_back(tw);
          taken++;
        end
      end
    end
    tw = '0;
    tw.summ = 1'b1;
    tw.cost = sum;
    tw.span = (taken == need);
    tw.ovf = graph_dropped;
    tw.last = 1'b1;
    tree_words_due.push_back(tw);
    graph_fill = 0;
    graph_dropped = 1'b0;
  endtask

  // Register writes only happen with nothing in flight. The sender is
  // parked first so that the last edge word is not taken a second time,
  // and a few idle cycles separate the graphs.
  task automatic write_vertex_count(input int value);
    start <= 1'b0;
    while (tree_words_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value[kmst_pkg::VC_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    vert_reg = value[kmst_pkg::VC_W-1:0];
  endtask

  // Presents one edge word and holds it until the block takes it. Between
  // bursts the sender rests for a random number of cycles.
  task automatic send_edge(input logic [5:0] s, input logic [5:0] d,
                           input logic [15:0] w, input logic lst,
                           input bit typed, input tree_word_t typed_word);
    start <= 1'b1;
    edge_src <= s;
    edge_dest <= d;
    edge_weight <= w;
    last_edge <= lst;
    do @(posedge clk); while (busy);
    add_edge_and_solve(s, d, w, lst);
    if (typed) begin
      void'(tree_words_due.pop_back());
      tree_words_due.push_back(typed_word);
    end
    items_sent++;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  // Result side: every strobed word is held against the oldest one due.
  always @(posedge clk) begin
    tree_word_t got, want;
    if (!rst && result_strobe) begin
      got = '{is_summary, tree_src, tree_dest, tree_weight, total_cost,
              spanning, store_overflow, last_result};
      if (tree_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", got));
      end else begin
        want = tree_words_due.pop_front();
        if (got.summ != want.summ) report_mismatch("is_summary");
        if (got.src != want.src) report_mismatch("tree_src");
        if (got.dest != want.dest) report_mismatch("tree_dest");
        if (got.weight != want.weight) report_mismatch("tree_weight");
        if (got.cost != want.cost) report_mismatch("total_cost");
        if (got.span != want.span) report_mismatch("spanning");
        if (got.ovf != want.ovf) report_mismatch("store_overflow");
        if (got.last != want.last) report_mismatch("last_result");
      end
    end
  end

  // Watchdog: ends the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || result_strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("FAIL kruskal_minimum_spanning_tree");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    edge_row_t rows[$];
    tree_word_t sw;
    int vc, ne, hi;
    logic [15:0] w;
    logic [5:0] s, d;

    rst = 1'b1;
    start = 1'b0;
    edge_src = '0;
    edge_dest = '0;
    edge_weight = '0;
    last_edge = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    graph_fill = 0;
    graph_dropped = 1'b0;
    vert_reg = 7'd64;

    // Directed table. Single-edge graphs have summaries that can be read off
    // directly; the rest go through the model.
    sw = '0; sw.summ = 1; sw.span = 1; sw.last = 1;
    // One vertex: nothing is needed, so the tree is complete and free.
    rows.push_back('{1, 6'd0, 6'd0, 16'd100, 1'b1, 1, sw});
    // A vertex count of zero behaves as one.
    rows.push_back('{0, 6'd5, 6'd3, 16'd7, 1'b1, 1, sw});
    sw.span = 0;
    // Self loop at the top vertex with the most negative weight: rejected.
    rows.push_back('{64, 6'd63, 6'd63, 16'h8000, 1'b1, 1, sw});
    // Counts above the vertex limit clamp; weight extremes and tied weights.
    rows.push_back('{127, 6'd0, 6'd1, 16'h7fff, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd1, 6'd2, 16'h8000, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd2, 6'd0, 16'd5, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd63, 6'd62, 16'hffff, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd2, 6'd1, 16'h8000, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd62, 6'd0, 16'd0, 1'b1, 0, sw});
    // Three vertices with an out of range endpoint and a redundant cycle.
    rows.push_back('{3, 6'd0, 6'd1, 16'd3, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd1, 6'd2, 16'd3, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd0, 6'd2, 16'd1, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd3, 6'd0, 16'hfffb, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd2, 6'd1, 16'd0, 1'b1, 0, sw});
    // Two vertices, two parallel edges of equal weight: the first one wins.
    rows.push_back('{2, 6'd1, 6'd0, 16'h8000, 1'b0, 0, sw});
    rows.push_back('{NO_CFG, 6'd0, 6'd1, 16'h8000, 1'b1, 0, sw});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].cfg != NO_CFG) write_vertex_count(rows[i].cfg);
      send_edge(rows[i].src, rows[i].dest, rows[i].weight, rows[i].last,
                rows[i].typed, rows[i].word);
    end

    // Random graphs. One of them overruns the edge store so that the drop
    // flag is seen; the rest stay small to keep the sort short.
    for (int g = 0; items_sent < 500; g++) begin
      case ($urandom_range(0, 9))
        0: vc = 0;
        1: vc = 127;
        2: vc = 64;
        3: vc = $urandom_range(0, 127);
        default: vc = $urandom_range(1, 12);
      endcase
      write_vertex_count(vc);
      hi = (vc < 1) ? 0 : (vc > NVERT) ? NVERT - 1 : vc - 1;
      ne = (g == 1) ? NEDGE + 3 : $urandom_range(1, 2 * hi + 3);
      for (int k = 0; k < ne; k++) begin
        s = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, hi));
        d = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, hi));
        w = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
        send_edge(s, d, w, k == ne - 1, 0, sw);
      end
    end
    start <= 1'b0;

    while (tree_words_due.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS kruskal_minimum_spanning_tree");
    end else begin
      $display("FAIL kruskal_minimum_spanning_tree");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/kmst_pkg.sv
hdl/kruskal_minimum_spanning_tree.sv
tb/tb_kruskal_minimum_spanning_tree.sv
